[rtl/alif_pkg.sv]
// ---------------------------------------------------------------------------
// alif_pkg
// Shared types and constants of the adjacent line intersection filter.
// ---------------------------------------------------------------------------
package alif_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int DATA_W      = 32;
   localparam int DIFF_W      = DATA_W + 1;
   localparam int DIV_W       = DIFF_W + FRAC_BITS;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_SIDE   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE_SELECT = 1'd1;

   localparam logic [1:0] SIDE_XHI_YLO = 2'd0;
   localparam logic [1:0] SIDE_XHI_YHI = 2'd1;
   localparam logic [1:0] SIDE_XLO_YHI = 2'd2;
   localparam logic [1:0] SIDE_XLO_YLO = 2'd3;

   typedef struct packed {
      logic                     pair;
      logic                     last;
      logic signed [DIFF_W-1:0] num;
      logic signed [DIFF_W-1:0] den;
      logic signed [DATA_W-1:0] prev_slope;
      logic signed [DATA_W-1:0] prev_intercept;
   } line_cmd_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] half_side;
      logic [1:0]               side_select;
   } cfg_type;

endpackage

[rtl/alif_if.sv]
// ---------------------------------------------------------------------------
// alif_if
// Valid/ready channels of the filter: line input, point output, CSR write.
// ---------------------------------------------------------------------------
interface alif_req_if;
   import alif_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] slope;
   logic signed [DATA_W-1:0] intercept;
   logic                     last_line;

   modport source (output valid, output slope, output intercept, output last_line,
                   input ready);
   modport sink (input valid, input slope, input intercept, input last_line,
                 output ready);
endinterface

interface alif_rsp_if;
   import alif_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] point_x;
   logic signed [DATA_W-1:0] point_y;
   logic                     has_point;
   logic                     end_of_list;

   modport source (output valid, output point_x, output point_y, output has_point,
                   output end_of_list, input ready);
   modport sink (input valid, input point_x, input point_y, input has_point,
                 input end_of_list, output ready);
endinterface

interface alif_csr_if;
   import alif_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [DATA_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/alif_front.sv]
// ---------------------------------------------------------------------------
// alif_front
// Accepts lines, keeps the previous line, forms differences and classifies.
// ---------------------------------------------------------------------------
module alif_front (
   input  logic                  clock,
   input  logic                  reset,
   alif_req_if.sink              req_bus,
   output logic                  push_valid,
   input  logic                  push_ready,
   output alif_pkg::line_cmd_type push_cmd
);
   import alif_pkg::*;

   logic signed [DATA_W-1:0] prev_slope_ff, prev_slope_in;
   logic signed [DATA_W-1:0] prev_intercept_ff, prev_intercept_in;
   logic                     have_prev_ff, have_prev_in;
   logic                     accept;

   always_comb begin
      push_cmd.den = {req_bus.slope[DATA_W-1], req_bus.slope}
                   - {prev_slope_ff[DATA_W-1], prev_slope_ff};
      push_cmd.num = {prev_intercept_ff[DATA_W-1], prev_intercept_ff}
                   - {req_bus.intercept[DATA_W-1], req_bus.intercept};
      push_cmd.pair           = have_prev_ff && (push_cmd.den != '0);
      push_cmd.last           = req_bus.last_line;
      push_cmd.prev_slope     = prev_slope_ff;
      push_cmd.prev_intercept = prev_intercept_ff;

      req_bus.ready = push_ready;
      accept        = req_bus.valid && push_ready;
      push_valid    = req_bus.valid && (push_cmd.pair || push_cmd.last);

      prev_slope_in     = prev_slope_ff;
      prev_intercept_in = prev_intercept_ff;
      have_prev_in      = have_prev_ff;
      if (accept) begin
         prev_slope_in     = req_bus.slope;
         prev_intercept_in = req_bus.intercept;
         have_prev_in      = !req_bus.last_line;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff      <= 1'b0;
         prev_slope_ff     <= '0;
         prev_intercept_ff <= '0;
      end else begin
         have_prev_ff      <= have_prev_in;
         prev_slope_ff     <= prev_slope_in;
         prev_intercept_ff <= prev_intercept_in;
      end
   end

endmodule

[rtl/alif_queue.sv]
// ---------------------------------------------------------------------------
// alif_queue
// Short FIFO of classified lines between front and back.
// ---------------------------------------------------------------------------
module alif_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  alif_pkg::line_cmd_type push_cmd,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output alif_pkg::line_cmd_type pop_cmd
);
   import alif_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   line_cmd_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
      pop_valid  = count_ff != '0;
      pop_cmd    = entry_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/alif_back.sv]
// ---------------------------------------------------------------------------
// alif_back
// Restoring divide for x, multiply-add for y, side filter and result register.
// ---------------------------------------------------------------------------
module alif_back (
   input  logic                   clock,
   input  logic                   reset,
   input  alif_pkg::cfg_type      cfg,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  alif_pkg::line_cmd_type pop_cmd,
   alif_rsp_if.source             rsp_bus
);
   import alif_pkg::*;

   localparam int CNT_W  = $clog2(DIV_W);
   localparam int SHR_W  = 2 * DATA_W - FRAC_BITS;
   localparam int SUM_W  = SHR_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_SAT, ST_MUL, ST_ADD, ST_DECIDE, ST_HOLD
   } state_type;

   state_type                  state_ff, state_in;
   line_cmd_type               cmd_ff, cmd_in;
   logic [DIFF_W-1:0]          rem_ff, rem_in;
   logic [DIFF_W-1:0]          den_ff, den_in;
   logic [DIV_W-1:0]           dq_ff, dq_in;
   logic                       neg_ff, neg_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic signed [DATA_W-1:0]   x_ff, x_in;
   logic signed [DATA_W-1:0]   y_ff, y_in;
   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic                       valid_ff, valid_in;
   logic signed [DATA_W-1:0]   px_ff, px_in;
   logic signed [DATA_W-1:0]   py_ff, py_in;
   logic                       has_ff, has_in;
   logic                       eol_ff, eol_in;

   logic [DIFF_W:0]            trial;
   logic                       ge;
   logic [DIFF_W-1:0]          mag_num, mag_den;
   logic signed [SHR_W-1:0]    shifted;
   logic signed [SUM_W-1:0]    sum;
   logic                       want_x, want_y, kept;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      dq_in    = dq_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      prod_in  = prod_ff;
      valid_in = valid_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      has_in   = has_ff;
      eol_in   = eol_ff;

      pop_ready = state_ff == ST_IDLE;

      mag_num = pop_cmd.num[DIFF_W-1] ? DIFF_W'(-pop_cmd.num) : DIFF_W'(pop_cmd.num);
      mag_den = pop_cmd.den[DIFF_W-1] ? DIFF_W'(-pop_cmd.den) : DIFF_W'(pop_cmd.den);

      trial = {rem_ff, dq_ff[DIV_W-1]};
      ge    = trial >= {1'b0, den_ff};

      shifted = prod_ff[2*DATA_W-1:FRAC_BITS];
      sum     = SUM_W'(shifted) + SUM_W'(cmd_ff.prev_intercept);

      want_x = (cfg.side_select == SIDE_XHI_YLO) || (cfg.side_select == SIDE_XHI_YHI);
      want_y = (cfg.side_select == SIDE_XHI_YHI) || (cfg.side_select == SIDE_XLO_YHI);
      kept   = ((x_ff >= cfg.half_side) == want_x) && ((y_ff >= cfg.half_side) == want_y);

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               cmd_in = pop_cmd;
               rem_in = '0;
               den_in = mag_den;
               dq_in  = {mag_num, {FRAC_BITS{1'b0}}};
               neg_in = pop_cmd.num[DIFF_W-1] ^ pop_cmd.den[DIFF_W-1];
               cnt_in = CNT_W'(DIV_W - 1);
               if (pop_cmd.pair) begin
                  state_in = ST_DIV;
               end else begin
                  px_in    = '0;
                  py_in    = '0;
                  has_in   = 1'b0;
                  eol_in   = 1'b1;
                  valid_in = 1'b1;
                  state_in = ST_HOLD;
               end
            end
         end
         ST_DIV: begin
            rem_in = ge ? DIFF_W'(trial - {1'b0, den_ff}) : trial[DIFF_W-1:0];
            dq_in  = {dq_ff[DIV_W-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            if (neg_ff) begin
               if ((|dq_ff[DIV_W-1:DATA_W]) || (dq_ff[DATA_W-1] && (|dq_ff[DATA_W-2:0]))) begin
                  x_in = {1'b1, {(DATA_W-1){1'b0}}};
               end else begin
                  x_in = DATA_W'(0) - dq_ff[DATA_W-1:0];
               end
            end else begin
               if (|dq_ff[DIV_W-1:DATA_W-1]) begin
                  x_in = {1'b0, {(DATA_W-1){1'b1}}};
               end else begin
                  x_in = dq_ff[DATA_W-1:0];
               end
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = cmd_ff.prev_slope * x_ff;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if ((&sum[SUM_W-1:DATA_W-1]) || !(|sum[SUM_W-1:DATA_W-1])) begin
               y_in = sum[DATA_W-1:0];
            end else if (sum[SUM_W-1]) begin
               y_in = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
               y_in = {1'b0, {(DATA_W-1){1'b1}}};
            end
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (kept || cmd_ff.last) begin
               px_in    = kept ? x_ff : '0;
               py_in    = kept ? y_ff : '0;
               has_in   = kept;
               eol_in   = cmd_ff.last;
               valid_in = 1'b1;
               state_in = ST_HOLD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_HOLD: begin
            if (rsp_bus.ready) begin
               valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      cmd_ff  <= cmd_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      dq_ff   <= dq_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      prod_ff <= prod_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      has_ff  <= has_in;
      eol_ff  <= eol_in;
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.point_x     = px_ff;
   assign rsp_bus.point_y     = py_ff;
   assign rsp_bus.has_point   = has_ff;
   assign rsp_bus.end_of_list = eol_ff;

endmodule

[rtl/adjacent_line_intersection_filter.sv]
// ---------------------------------------------------------------------------
// adjacent_line_intersection_filter
// Intersects each line with the one before it and keeps points on one side.
//
// Channels: req_bus takes lines (slope, intercept, last_line) in signed
// Q16.16; rsp_bus returns points (point_x, point_y, has_point, end_of_list);
// csr_bus writes half_side (index 0) and side_select (index 1), always ready.
// Write the registers only while no line is in flight.
// A line with a previous, non-parallel partner leaves the queue, passes the
// bit-serial restoring divider, then the saturate, multiply, add and filter
// stages before its result shows. A last line with no partner passes from the
// queue straight to the result register as its end item. The back end works
// on one line at a time and takes no new line until it is done with the last
// and its result, if any, is taken; a two-entry queue lets the front
// keep taking lines while the back end is busy or a result waits.
// Reset clears the stored line, the queue, the registers and any pending
// result. When the receiver stalls, the result holds in its output register,
// the back end stops, and req_bus ready drops once the queue is full.
// ---------------------------------------------------------------------------
module adjacent_line_intersection_filter (
   input  logic       clock,
   input  logic       reset,
   alif_req_if.sink   req_bus,
   alif_rsp_if.source rsp_bus,
   alif_csr_if.sink   csr_bus
);
   import alif_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         push_valid, push_ready;
   line_cmd_type push_cmd;
   logic         pop_valid, pop_ready;
   line_cmd_type pop_cmd;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_HALF_SIDE:   cfg_in.half_side   = csr_bus.data;
            CSR_SIDE_SELECT: cfg_in.side_select = csr_bus.data[1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   alif_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   alif_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   alif_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_bus   (rsp_bus)
   );

endmodule
